[rtl/mfrp_pkg.sv]
package mfrp_pkg;

  localparam int MAX_SYMBOLS = 256;
  localparam int SYM_CNT_W   = $clog2(MAX_SYMBOLS + 2);
  localparam int HDR_BYTES   = 23;
  localparam int HDR_IDX_W   = $clog2(HDR_BYTES);
  localparam int MIN_SYMBOLS = 10;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam int OUT_W       = 200;

  // frame bytes captured at the end of a good frame
  typedef struct packed {
    logic [7:0]                     length;
    logic [HDR_BYTES-1:0][7:0]      hdr;
  } snap_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // one byte through the MSB-first CRC-16
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[rtl/mfrp_frame.sv]
module mfrp_frame (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [3:0]          in_symbol,
  input  logic                in_last,
  input  logic                parse_ready,
  output logic                frame_ready,
  output logic                snap_valid,
  output mfrp_pkg::snap_t     snap
);

  logic                                         half_pending;
  logic [3:0]                                   low_nibble;
  logic [3:0][3:0]                              symbol_delay;
  logic [15:0]                                  crc_value;
  logic [mfrp_pkg::SYM_CNT_W-1:0]               symbol_count;
  logic [7:0]                                   byte_count;
  logic [mfrp_pkg::HDR_BYTES-1:0][7:0]          header_store;

  logic                                         half_pending_next;
  logic [3:0]                                   low_nibble_next;
  logic [3:0][3:0]                              symbol_delay_next;
  logic [15:0]                                  crc_value_next;
  logic [mfrp_pkg::SYM_CNT_W-1:0]               symbol_count_next;
  logic [7:0]                                   byte_count_next;
  logic [mfrp_pkg::HDR_BYTES-1:0][7:0]          header_store_next;

  logic        consume;
  logic        length_ok;
  logic        good_frame;
  logic [7:0]  data_byte;
  logic [7:0]  fcs0;
  logic [7:0]  fcs1;
  logic [15:0] fcs;

  assign frame_ready = !snap_valid || parse_ready;
  assign consume     = in_valid && frame_ready;
  assign data_byte   = {symbol_delay[0], low_nibble};

  always_comb begin
    half_pending_next = half_pending;
    low_nibble_next   = low_nibble;
    crc_value_next    = crc_value;
    byte_count_next   = byte_count;
    header_store_next = header_store;

    if (symbol_count >= mfrp_pkg::SYM_CNT_W'(4)) begin
      if (!half_pending) begin
        low_nibble_next   = symbol_delay[0];
        half_pending_next = 1'b1;
      end else begin
        if (byte_count_next < 8'(mfrp_pkg::HDR_BYTES)) begin
          header_store_next[byte_count_next[mfrp_pkg::HDR_IDX_W-1:0]] = data_byte;
        end
        if (byte_count_next != 8'hff) begin
          byte_count_next = byte_count_next + 8'd1;
        end
        crc_value_next    = mfrp_pkg::crc_byte(crc_value, mfrp_pkg::rev8(data_byte));
        half_pending_next = 1'b0;
      end
    end

    symbol_delay_next = {in_symbol, symbol_delay[3], symbol_delay[2], symbol_delay[1]};

    symbol_count_next = symbol_count;
    if (symbol_count <= mfrp_pkg::SYM_CNT_W'(mfrp_pkg::MAX_SYMBOLS)) begin
      symbol_count_next = symbol_count + mfrp_pkg::SYM_CNT_W'(1);
    end

    length_ok = (symbol_count_next >= mfrp_pkg::SYM_CNT_W'(mfrp_pkg::MIN_SYMBOLS)) &&
                (symbol_count_next <= mfrp_pkg::SYM_CNT_W'(mfrp_pkg::MAX_SYMBOLS));
    fcs0 = {symbol_delay_next[1], symbol_delay_next[0]};
    fcs1 = {symbol_delay_next[3], symbol_delay_next[2]};
    fcs  = {mfrp_pkg::rev8(fcs0), mfrp_pkg::rev8(fcs1)};

    // FCS bytes also land in the header store if the frame is that short
    if (in_last && length_ok) begin
      if (byte_count_next < 8'(mfrp_pkg::HDR_BYTES)) begin
        header_store_next[byte_count_next[mfrp_pkg::HDR_IDX_W-1:0]] = fcs0;
      end
      if (byte_count_next != 8'hff) begin
        byte_count_next = byte_count_next + 8'd1;
      end
      if (byte_count_next < 8'(mfrp_pkg::HDR_BYTES)) begin
        header_store_next[byte_count_next[mfrp_pkg::HDR_IDX_W-1:0]] = fcs1;
      end
      if (byte_count_next != 8'hff) begin
        byte_count_next = byte_count_next + 8'd1;
      end
    end

    good_frame = in_last && length_ok && (fcs == crc_value_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_pending <= 1'b0;
      low_nibble   <= '0;
      symbol_delay <= '0;
      crc_value    <= '0;
      symbol_count <= '0;
      byte_count   <= '0;
      header_store <= '0;
      snap_valid   <= 1'b0;
    end else begin
      if (consume) begin
        snap_valid <= good_frame;
        if (in_last) begin
          half_pending <= 1'b0;
          low_nibble   <= '0;
          symbol_delay <= '0;
          crc_value    <= '0;
          symbol_count <= '0;
          byte_count   <= '0;
          header_store <= '0;
        end else begin
          half_pending <= half_pending_next;
          low_nibble   <= low_nibble_next;
          symbol_delay <= symbol_delay_next;
          crc_value    <= crc_value_next;
          symbol_count <= symbol_count_next;
          byte_count   <= byte_count_next;
          header_store <= header_store_next;
        end
      end else if (parse_ready) begin
        snap_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && good_frame) begin
      snap.length <= byte_count_next;
      snap.hdr    <= header_store_next;
    end
  end

endmodule

[rtl/mfrp_parse.sv]
module mfrp_parse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          snap_valid,
  input  mfrp_pkg::snap_t               snap,
  output logic                          parse_ready,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mfrp_pkg::OUT_W-1:0]    m_tdata
);

  logic [mfrp_pkg::HDR_BYTES*8-1:0] flat;
  logic [15:0] fc;
  logic [2:0]  frame_kind;
  logic [1:0]  dmode;
  logic [1:0]  smode;
  logic        intra;
  logic        has_span;
  logic [4:0]  span_off;
  logic [4:0]  saddr_off;
  logic [4:0]  header_length;
  logic [63:0] daddr;
  logic [15:0] span;
  logic [63:0] saddr_raw;
  logic [63:0] saddr;

  assign parse_ready = !m_tvalid || m_tready;
  assign flat        = snap.hdr;
  assign fc          = {snap.hdr[1], snap.hdr[0]};
  assign dmode       = fc[11:10];
  assign smode       = fc[15:14];
  assign intra       = fc[6];
  assign frame_kind  = fc[2] ? 3'd4 : {1'b0, fc[1:0]};
  assign has_span    = !intra && smode[1] && dmode[1];

  always_comb begin
    case (dmode)
      2'd2: begin
        daddr    = {48'd0, flat[40 +: 16]};
        span_off = 5'd7;
      end
      2'd3: begin
        daddr    = flat[40 +: 64];
        span_off = 5'd13;
      end
      default: begin
        daddr    = '0;
        span_off = 5'd5;
      end
    endcase

    span      = '0;
    saddr_off = span_off;
    if (has_span) begin
      saddr_off = span_off + 5'd2;
      case (span_off)
        5'd7:    span = flat[56 +: 16];
        default: span = flat[104 +: 16];
      endcase
    end

    case (saddr_off)
      5'd7:    saddr_raw = flat[56 +: 64];
      5'd9:    saddr_raw = flat[72 +: 64];
      5'd13:   saddr_raw = flat[104 +: 64];
      5'd15:   saddr_raw = flat[120 +: 64];
      default: saddr_raw = flat[40 +: 64];
    endcase

    case (smode)
      2'd2: begin
        saddr         = {48'd0, saddr_raw[15:0]};
        header_length = saddr_off + 5'd2;
      end
      2'd3: begin
        saddr         = saddr_raw;
        header_length = saddr_off + 5'd8;
      end
      default: begin
        saddr         = '0;
        header_length = saddr_off;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (parse_ready) begin
      m_tvalid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (parse_ready && snap_valid) begin
      m_tdata <= {6'd0, header_length, saddr, span, daddr, flat[24 +: 16], flat[16 +: 8],
                  fc[13:12], smode, dmode, fc[6:3], frame_kind, snap.length};
    end
  end

endmodule

[rtl/mac_frame_receive_parser.sv]
// A frame's result passes through the input register, the frame state update and
//   the header decode into the output register.
// Throughput: one symbol per cycle unless the output stalls; the CRC takes a byte
//   every second symbol. Reset (rst, synchronous): clears all frame state, the
//   header bytes and every valid flag; s_tready is high once reset is released.
module mac_frame_receive_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // [3:0] symbol, [7:4] zero
  input  logic                          s_tlast,  // last
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [7:0] length_bytes, [10:8] frame_kind, [14:11] flags, [18:15] address_modes,
  // [20:19] fc_version, [28:21] seq_num, [44:29] dest_pan,
  // [108:45] dst_addr, [124:109] source_pan, [188:125] src_addr,
  // [193:189] header_length, [199:194] zero
  output logic [mfrp_pkg::OUT_W-1:0]    m_tdata
);

  logic            in_valid;
  logic [3:0]      in_symbol;
  logic            in_last;
  logic            frame_ready;
  logic            snap_valid;
  logic            parse_ready;
  mfrp_pkg::snap_t snap;

  assign s_tready = !in_valid || frame_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_symbol <= s_tdata[3:0];
      in_last   <= s_tlast;
    end
  end

  mfrp_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_symbol   (in_symbol),
    .in_last     (in_last),
    .parse_ready (parse_ready),
    .frame_ready (frame_ready),
    .snap_valid  (snap_valid),
    .snap        (snap)
  );

  mfrp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .snap_valid  (snap_valid),
    .snap        (snap),
    .parse_ready (parse_ready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  a_len_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:0] >= 8'd5)
    else $error("result length below five bytes");

  a_hlen_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[193:189] >= 5'd5) && (m_tdata[193:189] <= 5'd23))
    else $error("header length out of range");

  a_type_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[10:8] <= 3'd4)
    else $error("frame type out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && snap_valid && m_tvalid)
    else $error("input stalled while pipeline has room");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && !snap_valid && !in_valid)
    else $error("valid flag set after reset");

endmodule
